>>> rtl/gcnms_pkg.sv
// ----------------------------------------------------------------------------
// gcnms_pkg
// Types and constants for the greedy class-aware NMS block.
// ----------------------------------------------------------------------------
package gcnms_pkg;

	localparam int MAX_BOXES = 64;
	localparam int IDX_W = $clog2(MAX_BOXES);
	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam logic [15:0] THR_RESET = 16'd29491;

	typedef struct packed {
		logic [3:0] class_id;
		logic [15:0] score;
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic signed [15:0] right;
		logic signed [15:0] bottom;
		logic last_box;
	} box_in_t;

	typedef struct packed {
		logic [3:0] kept_class;
		logic [15:0] kept_score;
		logic signed [15:0] kept_left;
		logic signed [15:0] kept_top;
		logic signed [15:0] kept_right;
		logic signed [15:0] kept_bottom;
		logic none_kept;
		logic overflow;
		logic last_result;
	} box_out_t;

	typedef struct packed {
		logic [3:0] cls;
		logic [15:0] score;
		logic [63:0] coord;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_SORT_RD,
		ST_SORT_CUR,
		ST_SORT_CMP,
		ST_SORT_PIDX,
		ST_SORT_PSC,
		ST_OUTER_RD,
		ST_OUTER_IDX,
		ST_OUTER_CHK,
		ST_INNER_RD,
		ST_INNER_IDX,
		ST_INNER_GEO,
		ST_INNER_MUL,
		ST_INNER_UNI,
		ST_INNER_CMP,
		ST_EMIT,
		ST_EMPTY
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic store;
		logic clear;
		logic sort_init;
		logic sort_rd_cur;
		logic sort_load_cur;
		logic sort_rd_prev;
		logic sort_prev_idx;
		logic sort_shift;
		logic sort_place;
		logic outer_init;
		logic outer_rd;
		logic outer_latch;
		logic outer_chk;
		logic outer_next;
		logic inner_init;
		logic inner_rd;
		logic inner_latch;
		logic inner_geo;
		logic inner_mul;
		logic inner_uni;
		logic inner_cmp;
		logic inner_next;
		logic emit;
		logic emit_empty;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic sort_done;
		logic sort_stop;
		logic sort_less;
		logic outer_done;
		logic a_supp;
		logic inner_done;
		logic any_kept;
	} stat_t;

endpackage

>>> rtl/gcnms_ram.sv
// ----------------------------------------------------------------------------
// gcnms_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module gcnms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/gcnms_dp.sv
// ----------------------------------------------------------------------------
// gcnms_dp
// Datapath: box store, sort order, suppression flags and IoU test.
// ----------------------------------------------------------------------------
module gcnms_dp (
	input  logic clk,
	input  logic arst_n,
	input  gcnms_pkg::cmd_t cmd,
	input  gcnms_pkg::box_in_t box,
	input  logic [15:0] thr,
	output gcnms_pkg::stat_t stat,
	output gcnms_pkg::box_out_t res
);
	localparam int IW = gcnms_pkg::IDX_W;
	localparam int CW = gcnms_pkg::CNT_W;

	logic [CW-1:0] count_q;
	logic ovf_q;
	logic [gcnms_pkg::MAX_BOXES-1:0] supp_q;
	logic kept_q;
	logic surv_q;

	// box store: entries by load index
	logic st_we;
	logic [IW-1:0] st_raddr;
	gcnms_pkg::entry_t st_wdata, st_rdata;

	// order memory: sorted position -> load index
	logic ord_we;
	logic [IW-1:0] ord_waddr, ord_raddr, ord_wdata, ord_rdata;

	logic [CW-1:0] i_q, j_q;
	logic [15:0] cur_score_q;
	logic [IW-1:0] prev_idx_q;

	gcnms_pkg::entry_t a_q;
	logic [IW-1:0] a_idx_q;
	logic [IW-1:0] b_idx_q;

	assign st_we = cmd.store && !stat.full;
	assign st_wdata = '{cls: box.class_id, score: box.score,
		coord: {box.bottom, box.right, box.top, box.left}};

	gcnms_ram #(.WIDTH(gcnms_pkg::ENTRY_W), .DEPTH(gcnms_pkg::MAX_BOXES)) u_store (
		.clk(clk), .we(st_we), .waddr(count_q[IW-1:0]), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	gcnms_ram #(.WIDTH(IW), .DEPTH(gcnms_pkg::MAX_BOXES)) u_order (
		.clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
		.raddr(ord_raddr), .rdata(ord_rdata)
	);

	// sort and walk address muxing
	always_comb begin
		st_raddr = i_q[IW-1:0];
		if (cmd.sort_prev_idx || cmd.outer_latch || cmd.inner_latch) begin
			st_raddr = ord_rdata;
		end
		ord_raddr = IW'(j_q - CW'(1));
		if (cmd.outer_rd) begin
			ord_raddr = i_q[IW-1:0];
		end else if (cmd.inner_rd) begin
			ord_raddr = j_q[IW-1:0];
		end
		ord_we = cmd.sort_shift || cmd.sort_place;
		ord_waddr = j_q[IW-1:0];
		ord_wdata = cmd.sort_shift ? prev_idx_q : i_q[IW-1:0];
	end

	// IoU pipeline
	logic signed [16:0] ix0, iy0, ix1, iy1, iw, ih, aw, ah, bw, bh;
	logic signed [16:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
	logic [16:0] iw_s1, ih_s1, aw_s1, ah_s1, bw_s1, bh_s1;
	logic same_s1, ok_s1;
	logic [33:0] inter_s2, area_a_s2, area_b_s2;
	logic same_s2, ok_s2;
	logic [34:0] uni_s3;
	logic [33:0] inter_s3;
	logic same_s3, ok_s3;
	logic [50:0] lhs, rhs;
	logic over;

	always_comb begin
		ax0 = 17'(signed'(a_q.coord[15:0]));
		ay0 = 17'(signed'(a_q.coord[31:16]));
		ax1 = 17'(signed'(a_q.coord[47:32]));
		ay1 = 17'(signed'(a_q.coord[63:48]));
		bx0 = 17'(signed'(st_rdata.coord[15:0]));
		by0 = 17'(signed'(st_rdata.coord[31:16]));
		bx1 = 17'(signed'(st_rdata.coord[47:32]));
		by1 = 17'(signed'(st_rdata.coord[63:48]));
		ix0 = (ax0 > bx0) ? ax0 : bx0;
		iy0 = (ay0 > by0) ? ay0 : by0;
		ix1 = (ax1 < bx1) ? ax1 : bx1;
		iy1 = (ay1 < by1) ? ay1 : by1;
		iw = ix1 - ix0;
		ih = iy1 - iy0;
		aw = ax1 - ax0;
		ah = ay1 - ay0;
		bw = bx1 - bx0;
		bh = by1 - by0;
		lhs = {1'b0, inter_s3, 16'b0};
		rhs = 51'(uni_s3) * 51'(thr);
		over = lhs > rhs;
	end

	always_ff @(posedge clk) begin
		if (cmd.inner_geo) begin
			iw_s1 <= iw[16] ? '0 : iw;
			ih_s1 <= ih[16] ? '0 : ih;
			aw_s1 <= aw[16] ? '0 : aw;
			ah_s1 <= ah[16] ? '0 : ah;
			bw_s1 <= bw[16] ? '0 : bw;
			bh_s1 <= bh[16] ? '0 : bh;
			same_s1 <= st_rdata.cls == a_q.cls;
			ok_s1 <= !supp_q[b_idx_q];
		end
		if (cmd.inner_mul) begin
			inter_s2 <= 34'(iw_s1) * 34'(ih_s1);
			area_a_s2 <= 34'(aw_s1) * 34'(ah_s1);
			area_b_s2 <= 34'(bw_s1) * 34'(bh_s1);
			same_s2 <= same_s1;
			ok_s2 <= ok_s1;
		end
		if (cmd.inner_uni) begin
			uni_s3 <= 35'(area_a_s2) + 35'(area_b_s2) - 35'(inter_s2);
			inter_s3 <= inter_s2;
			same_s3 <= same_s2;
			ok_s3 <= ok_s2;
		end
		if (cmd.sort_load_cur) begin
			cur_score_q <= st_rdata.score;
		end
		if (cmd.sort_prev_idx) begin
			prev_idx_q <= ord_rdata;
		end
		if (cmd.outer_latch) begin
			a_idx_q <= ord_rdata;
		end
		if (cmd.outer_chk) begin
			a_q <= st_rdata;
		end
		if (cmd.inner_latch) begin
			b_idx_q <= ord_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
			supp_q <= '0;
			kept_q <= 1'b0;
			surv_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
				ovf_q <= 1'b0;
				kept_q <= 1'b0;
			end else if (cmd.store) begin
				if (stat.full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
					supp_q[count_q[IW-1:0]] <= 1'b0;
				end
			end
			if (cmd.sort_init || cmd.outer_init) begin
				i_q <= '0;
			end else if (cmd.sort_place || cmd.outer_next) begin
				i_q <= i_q + CW'(1);
			end
			if (cmd.sort_rd_cur) begin
				j_q <= i_q;
			end else if (cmd.sort_shift) begin
				j_q <= j_q - CW'(1);
			end else if (cmd.inner_init) begin
				j_q <= i_q + CW'(1);
			end else if (cmd.inner_next) begin
				j_q <= j_q + CW'(1);
			end
			if (cmd.inner_init) begin
				surv_q <= 1'b0;
			end else if (cmd.inner_cmp && ok_s3 && !(same_s3 && over)) begin
				surv_q <= 1'b1;
			end
			if (cmd.inner_cmp && ok_s3 && same_s3 && over) begin
				supp_q[b_idx_q] <= 1'b1;
			end
			if (cmd.emit) begin
				kept_q <= 1'b1;
			end
		end
	end

	assign stat.full = count_q == CW'(gcnms_pkg::MAX_BOXES);
	assign stat.sort_done = i_q == count_q;
	assign stat.sort_stop = j_q == '0;
	assign stat.sort_less = st_rdata.score < cur_score_q;
	assign stat.outer_done = i_q == count_q;
	assign stat.a_supp = supp_q[a_idx_q];
	assign stat.inner_done = j_q == count_q;
	assign stat.any_kept = kept_q;

	// a kept box is the last one when no later box survived its pass
	always_comb begin
		res = '0;
		res.overflow = ovf_q;
		if (cmd.emit) begin
			res.kept_class = a_q.cls;
			res.kept_score = a_q.score;
			res.kept_left = a_q.coord[15:0];
			res.kept_top = a_q.coord[31:16];
			res.kept_right = a_q.coord[47:32];
			res.kept_bottom = a_q.coord[63:48];
			res.last_result = !surv_q;
		end else if (cmd.emit_empty) begin
			res.none_kept = 1'b1;
			res.last_result = 1'b1;
		end
	end
endmodule

>>> rtl/gcnms_ctrl.sv
// ----------------------------------------------------------------------------
// gcnms_ctrl
// Controller: load, sort, greedy walk and emission sequencing.
// ----------------------------------------------------------------------------
module gcnms_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic last_box,
	input  gcnms_pkg::stat_t stat,
	output gcnms_pkg::cmd_t cmd,
	output logic busy
);
	gcnms_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcnms_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		busy = state_q != gcnms_pkg::ST_LOAD;
		unique case (state_q)
			gcnms_pkg::ST_LOAD: begin
				if (start) begin
					cmd.store = 1'b1;
					if (last_box) begin
						cmd.sort_init = 1'b1;
						state_d = gcnms_pkg::ST_SORT_RD;
					end
				end
			end
			gcnms_pkg::ST_SORT_RD: begin
				if (stat.sort_done) begin
					cmd.outer_init = 1'b1;
					state_d = gcnms_pkg::ST_OUTER_RD;
				end else begin
					cmd.sort_rd_cur = 1'b1;
					state_d = gcnms_pkg::ST_SORT_CUR;
				end
			end
			gcnms_pkg::ST_SORT_CUR: begin
				cmd.sort_load_cur = 1'b1;
				state_d = gcnms_pkg::ST_SORT_CMP;
			end
			gcnms_pkg::ST_SORT_CMP: begin
				if (stat.sort_stop) begin
					cmd.sort_place = 1'b1;
					state_d = gcnms_pkg::ST_SORT_RD;
				end else begin
					cmd.sort_rd_prev = 1'b1;
					state_d = gcnms_pkg::ST_SORT_PIDX;
				end
			end
			gcnms_pkg::ST_SORT_PIDX: begin
				cmd.sort_prev_idx = 1'b1;
				state_d = gcnms_pkg::ST_SORT_PSC;
			end
			gcnms_pkg::ST_SORT_PSC: begin
				if (stat.sort_less) begin
					cmd.sort_shift = 1'b1;
					state_d = gcnms_pkg::ST_SORT_CMP;
				end else begin
					cmd.sort_place = 1'b1;
					state_d = gcnms_pkg::ST_SORT_RD;
				end
			end
			gcnms_pkg::ST_OUTER_RD: begin
				if (stat.outer_done) begin
					if (stat.any_kept) begin
						cmd.clear = 1'b1;
						state_d = gcnms_pkg::ST_LOAD;
					end else begin
						state_d = gcnms_pkg::ST_EMPTY;
					end
				end else begin
					cmd.outer_rd = 1'b1;
					state_d = gcnms_pkg::ST_OUTER_IDX;
				end
			end
			gcnms_pkg::ST_OUTER_IDX: begin
				cmd.outer_latch = 1'b1;
				state_d = gcnms_pkg::ST_OUTER_CHK;
			end
			gcnms_pkg::ST_OUTER_CHK: begin
				cmd.outer_chk = 1'b1;
				if (stat.a_supp) begin
					cmd.outer_next = 1'b1;
					state_d = gcnms_pkg::ST_OUTER_RD;
				end else begin
					cmd.inner_init = 1'b1;
					state_d = gcnms_pkg::ST_INNER_RD;
				end
			end
			gcnms_pkg::ST_INNER_RD: begin
				if (stat.inner_done) begin
					state_d = gcnms_pkg::ST_EMIT;
				end else begin
					cmd.inner_rd = 1'b1;
					state_d = gcnms_pkg::ST_INNER_IDX;
				end
			end
			gcnms_pkg::ST_INNER_IDX: begin
				cmd.inner_latch = 1'b1;
				state_d = gcnms_pkg::ST_INNER_GEO;
			end
			gcnms_pkg::ST_INNER_GEO: begin
				cmd.inner_geo = 1'b1;
				state_d = gcnms_pkg::ST_INNER_MUL;
			end
			gcnms_pkg::ST_INNER_MUL: begin
				cmd.inner_mul = 1'b1;
				state_d = gcnms_pkg::ST_INNER_UNI;
			end
			gcnms_pkg::ST_INNER_UNI: begin
				cmd.inner_uni = 1'b1;
				state_d = gcnms_pkg::ST_INNER_CMP;
			end
			gcnms_pkg::ST_INNER_CMP: begin
				cmd.inner_cmp = 1'b1;
				cmd.inner_next = 1'b1;
				state_d = gcnms_pkg::ST_INNER_RD;
			end
			gcnms_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
				cmd.outer_next = 1'b1;
				state_d = gcnms_pkg::ST_OUTER_RD;
			end
			gcnms_pkg::ST_EMPTY: begin
				cmd.emit_empty = 1'b1;
				cmd.clear = 1'b1;
				state_d = gcnms_pkg::ST_LOAD;
			end
			default: state_d = gcnms_pkg::ST_LOAD;
		endcase
	end
endmodule

>>> rtl/greedy_class_aware_nms.sv
// ----------------------------------------------------------------------------
// greedy_class_aware_nms
// Class-aware greedy NMS over one set of up to 64 boxes.
// Load: one box per cycle, busy low. After the last box an insertion sort
// orders the boxes by descending score; the walk then reads them in that
// order, tests each later box against a kept box and strobes the kept box
// for one cycle as soon as its pairs are done. One set at a time.
// Reset clears the set and restores the threshold; stores need no clearing.
// The receiver cannot stall: each result is strobed for one cycle.
// ----------------------------------------------------------------------------
module greedy_class_aware_nms (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  gcnms_pkg::box_in_t box,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [15:0] cfg_data,
	output logic result_valid,
	output gcnms_pkg::box_out_t result
);
	gcnms_pkg::cmd_t cmd;
	gcnms_pkg::stat_t stat;
	logic [15:0] thr_q;

	assign cfg_ready = !busy;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= gcnms_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	gcnms_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .last_box(box.last_box),
		.stat(stat), .cmd(cmd), .busy(busy)
	);

	gcnms_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .box(box), .thr(thr_q),
		.stat(stat), .res(result)
	);

	assign result_valid = cmd.emit || cmd.emit_empty;
endmodule
